FILE: hw/rtl/hmv_pkg.sv
// Shared types and constants for the histogram mean/variance block.
// No dependencies; every other file refers to it by scoped names.
package hmv_pkg;

  // Field and accumulator widths
  localparam int CNT_W   = 32;
  localparam int TOT_W   = 42;
  localparam int S1_W    = 52;
  localparam int S2_W    = 62;
  localparam int MEAN_W  = 26;
  localparam int VAR_W   = 34;

  // Shared datapath widths: widest product is total*s2 (also covers s1*s1)
  localparam int PROD_W  = TOT_W + S2_W;
  localparam int DEN2_W  = 2 * TOT_W;
  localparam int MQ_W    = S1_W;
  localparam int STEP_W  = $clog2(S1_W + 1);

  // Stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  // Parameter defaults
  localparam int MAX_BINS_DEF      = 1024;
  localparam int FRACTION_BITS_DEF = 16;

  // Status codes
  localparam logic ST_OK        = 1'b0;
  localparam logic ST_RANGE_ERR = 1'b1;

  // Accumulated state seen by the final calculation
  typedef struct packed {
    logic [TOT_W-1:0] total;
    logic [S1_W-1:0]  s1;
    logic [S2_W-1:0]  s2;
    logic             ovf;
  } acc_t;

  // Per-bin accumulator controls
  typedef struct packed {
    logic take;
    logic add;
    logic clear;
    logic last;
  } acc_ctl_t;

  // Shared add/subtract unit controls
  typedef struct packed {
    logic shift;
    logic in_bit;
    logic sub;
  } alu_ctl_t;

endpackage

FILE: hw/rtl/hmv_accum.sv
// Per-bin accumulation: total, sum of count*index, sum of count*index^2.
// Depends on hmv_pkg. Saturating adds, index counter, overflow flag.
module hmv_accum #(
  parameter int MAX_BINS = hmv_pkg::MAX_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hmv_pkg::acc_ctl_t           ctl_i,
  input  logic [hmv_pkg::CNT_W-1:0]   cnt_i,
  output hmv_pkg::acc_t               acc_o
);

  localparam int IW   = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
  localparam int P1_W = hmv_pkg::CNT_W + IW;
  localparam int P2_W = hmv_pkg::CNT_W + 2 * IW;

  logic [IW-1:0]              idx_r, idx_nxt;
  logic [hmv_pkg::TOT_W-1:0]  total_r, total_nxt;
  logic [hmv_pkg::S1_W-1:0]   s1_r, s1_nxt;
  logic [hmv_pkg::S2_W-1:0]   s2_r, s2_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [P1_W-1:0]            p1_r, p1_nxt;
  logic [P2_W-1:0]            p2_r, p2_nxt;
  logic                       p2_v_r, p2_v_nxt;

  logic [hmv_pkg::TOT_W:0]    tot_sum;
  logic [hmv_pkg::S1_W:0]     s1_sum;
  logic [hmv_pkg::S2_W:0]     s2_sum;

  // Widened sums, carry-out means saturation
  assign tot_sum = {1'b0, total_r} + (hmv_pkg::TOT_W + 1)'(cnt_i);
  assign s1_sum  = {1'b0, s1_r} + (hmv_pkg::S1_W + 1)'(p1_r);
  assign s2_sum  = {1'b0, s2_r} + (hmv_pkg::S2_W + 1)'(p2_r);

  // Next state: total on take, s1 on add, s2 in the cycle after add
  always_comb begin
    idx_nxt   = idx_r;
    total_nxt = total_r;
    s1_nxt    = s1_r;
    s2_nxt    = s2_r;
    ovf_nxt   = ovf_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    p2_v_nxt  = 1'b0;

    if (ctl_i.take) begin
      p1_nxt = P1_W'(cnt_i) * P1_W'(idx_r);
      if (tot_sum[hmv_pkg::TOT_W]) begin
        total_nxt = '1;
        ovf_nxt   = 1'b1;
      end else begin
        total_nxt = tot_sum[hmv_pkg::TOT_W-1:0];
      end
    end

    if (ctl_i.add) begin
      p2_nxt   = P2_W'(p1_r) * P2_W'(idx_r);
      p2_v_nxt = 1'b1;
      if (s1_sum[hmv_pkg::S1_W]) begin
        s1_nxt  = '1;
        ovf_nxt = 1'b1;
      end else begin
        s1_nxt = s1_sum[hmv_pkg::S1_W-1:0];
      end
      // index saturates at the last bin slot
      if (!ctl_i.last) begin
        if (idx_r == IW'(MAX_BINS - 1)) begin
          ovf_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end

    if (p2_v_r) begin
      if (s2_sum[hmv_pkg::S2_W]) begin
        s2_nxt  = '1;
        ovf_nxt = 1'b1;
      end else begin
        s2_nxt = s2_sum[hmv_pkg::S2_W-1:0];
      end
    end

    if (ctl_i.clear) begin
      idx_nxt   = '0;
      total_nxt = '0;
      s1_nxt    = '0;
      s2_nxt    = '0;
      ovf_nxt   = 1'b0;
      p2_v_nxt  = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      total_r <= '0;
      s1_r    <= '0;
      s2_r    <= '0;
      ovf_r   <= 1'b0;
      p2_v_r  <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      total_r <= total_nxt;
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      ovf_r   <= ovf_nxt;
      p2_v_r  <= p2_v_nxt;
    end
  end

  // Product pipeline registers
  always_ff @(posedge clk) begin
    p1_r <= p1_nxt;
    p2_r <= p2_nxt;
  end

  assign acc_o = '{total: total_r, s1: s1_r, s2: s2_r, ovf: ovf_r};

endmodule

FILE: hw/rtl/hmv_alu.sv
// Shared add/subtract unit with optional one-bit left shift of the accumulator.
// Depends on hmv_pkg. Serves shift-add multiply and restoring-divide steps.
module hmv_alu (
  input  hmv_pkg::alu_ctl_t            ctl_i,
  input  logic [hmv_pkg::PROD_W-1:0]   acc_i,
  input  logic [hmv_pkg::PROD_W-1:0]   op_i,
  output logic [hmv_pkg::PROD_W-1:0]   res_o,
  output logic [hmv_pkg::PROD_W-1:0]   pass_o,
  output logic                         ge_o
);

  localparam int W = hmv_pkg::PROD_W;

  logic [W:0]   base;
  logic [W+1:0] opx;
  logic [W+1:0] sum;

  // Shift in one bit, then add or subtract the operand
  always_comb begin
    base = ctl_i.shift ? {acc_i, ctl_i.in_bit} : {1'b0, acc_i};
    opx  = ctl_i.sub ? ~{2'b00, op_i} : {2'b00, op_i};
    sum  = {1'b0, base} + opx + (W + 2)'(ctl_i.sub);
  end

  assign res_o  = sum[W-1:0];
  assign pass_o = base[W-1:0];
  // no borrow on subtract: shifted value >= operand
  assign ge_o   = ~sum[W+1];

endmodule

FILE: hw/rtl/hmv_calc.sv
// Final mean/variance sequencer: three shift-add products and two restoring
// divisions, all on the shared hmv_alu. Depends on hmv_pkg and hmv_alu.
module hmv_calc #(
  parameter int FRACTION_BITS = hmv_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic                         ack_i,
  input  hmv_pkg::acc_t                acc_i,
  output logic                         done_o,
  output logic [hmv_pkg::MEAN_W-1:0]   mean_o,
  output logic [hmv_pkg::VAR_W-1:0]    var_o,
  output logic                         status_o
);

  localparam int PW   = hmv_pkg::PROD_W;
  localparam int SW   = hmv_pkg::STEP_W;
  localparam int NM_W = hmv_pkg::S1_W + FRACTION_BITS;
  localparam int NV_W = PW + FRACTION_BITS;

  typedef enum logic [9:0] {
    C_IDLE = 10'b00_0000_0001,
    C_MULB = 10'b00_0000_0010,
    C_MULA = 10'b00_0000_0100,
    C_DIFF = 10'b00_0000_1000,
    C_MULC = 10'b00_0001_0000,
    C_MCHK = 10'b00_0010_0000,
    C_MDIV = 10'b00_0100_0000,
    C_VCHK = 10'b00_1000_0000,
    C_VDIV = 10'b01_0000_0000,
    C_DONE = 10'b10_0000_0000
  } calc_state_t;

  calc_state_t                   state_r, state_nxt;
  logic [SW-1:0]                 step_r, step_nxt;
  logic [hmv_pkg::MQ_W-1:0]      mq_r, mq_nxt;
  logic [PW-1:0]                 acc_r, acc_nxt;
  logic [PW-1:0]                 x_r, x_nxt;
  logic [hmv_pkg::DEN2_W-1:0]    den2_r, den2_nxt;
  logic [hmv_pkg::VAR_W-1:0]     nq_r, nq_nxt;
  logic [hmv_pkg::MEAN_W-1:0]    mean_r, mean_nxt;
  logic                          var_pos_r, var_pos_nxt;
  logic                          bad_r, bad_nxt;

  hmv_pkg::alu_ctl_t             alu_ctl;
  logic [PW-1:0]                 alu_op;
  logic [PW-1:0]                 alu_res;
  logic [PW-1:0]                 alu_pass;
  logic                          alu_ge;

  logic                          last_step;
  logic                          go_var;
  logic [PW-1:0]                 div_nxt;
  logic [hmv_pkg::MQ_W-1:0]      tot_aligned;
  logic [NM_W-1:0]               num_m;
  logic [NV_W-1:0]               num_v;
  logic [PW-1:0]                 rem_m;
  logic [PW-1:0]                 rem_v;
  logic [hmv_pkg::MEAN_W-1:0]    low_m;
  logic [hmv_pkg::VAR_W-1:0]     low_v;

  hmv_alu u_alu (
    .ctl_i  (alu_ctl),
    .acc_i  (acc_r),
    .op_i   (alu_op),
    .res_o  (alu_res),
    .pass_o (alu_pass),
    .ge_o   (alu_ge)
  );

  // Operand preparation: scaled numerators split into the part that seeds
  // the remainder and the part that is shifted in bit by bit
  assign tot_aligned = {acc_i.total, {(hmv_pkg::MQ_W - hmv_pkg::TOT_W){1'b0}}};
  assign num_m       = {acc_i.s1, {FRACTION_BITS{1'b0}}};
  assign num_v       = {x_r, {FRACTION_BITS{1'b0}}};
  assign rem_m       = PW'(num_m >> hmv_pkg::MEAN_W);
  assign rem_v       = PW'(num_v >> hmv_pkg::VAR_W);
  assign low_m       = num_m[hmv_pkg::MEAN_W-1:0];
  assign low_v       = num_v[hmv_pkg::VAR_W-1:0];
  assign last_step   = (step_r == SW'(1));
  assign div_nxt     = alu_ge ? alu_res : alu_pass;

  // Shared unit control per state
  always_comb begin
    alu_ctl = '{shift: 1'b0, in_bit: 1'b0, sub: 1'b0};
    alu_op  = '0;
    unique case (state_r)
      C_MULB: begin
        alu_ctl.shift = 1'b1;
        alu_op = mq_r[hmv_pkg::MQ_W-1] ? PW'(acc_i.s1) : '0;
      end
      C_MULA: begin
        alu_ctl.shift = 1'b1;
        alu_op = mq_r[hmv_pkg::MQ_W-1] ? PW'(acc_i.s2) : '0;
      end
      C_DIFF: begin
        alu_ctl.sub = 1'b1;
        alu_op = x_r;
      end
      C_MULC: begin
        alu_ctl.shift = 1'b1;
        alu_op = mq_r[hmv_pkg::MQ_W-1] ? PW'(acc_i.total) : '0;
      end
      C_MCHK: begin
        alu_ctl.sub = 1'b1;
        alu_op = PW'(acc_i.total);
      end
      C_MDIV: begin
        alu_ctl = '{shift: 1'b1, in_bit: nq_r[hmv_pkg::VAR_W-1], sub: 1'b1};
        alu_op  = PW'(acc_i.total);
      end
      C_VCHK: begin
        alu_ctl.sub = 1'b1;
        alu_op = PW'(den2_r);
      end
      C_VDIV: begin
        alu_ctl = '{shift: 1'b1, in_bit: nq_r[hmv_pkg::VAR_W-1], sub: 1'b1};
        alu_op  = PW'(den2_r);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    mq_nxt      = mq_r;
    acc_nxt     = acc_r;
    x_nxt       = x_r;
    den2_nxt    = den2_r;
    nq_nxt      = nq_r;
    mean_nxt    = mean_r;
    var_pos_nxt = var_pos_r;
    bad_nxt     = bad_r;
    go_var      = 1'b0;

    unique case (state_r)
      C_IDLE: begin
        if (start_i) begin
          if (acc_i.total == '0) begin
            // zero total: zeros with range error
            mean_nxt  = '0;
            nq_nxt    = '0;
            bad_nxt   = 1'b1;
            state_nxt = C_DONE;
          end else begin
            bad_nxt   = 1'b0;
            acc_nxt   = '0;
            mq_nxt    = acc_i.s1;
            step_nxt  = SW'(hmv_pkg::S1_W);
            state_nxt = C_MULB;
          end
        end
      end
      // s1*s1 into x
      C_MULB: begin
        acc_nxt  = alu_res;
        mq_nxt   = mq_r << 1;
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          x_nxt     = alu_res;
          acc_nxt   = '0;
          mq_nxt    = tot_aligned;
          step_nxt  = SW'(hmv_pkg::TOT_W);
          state_nxt = C_MULA;
        end
      end
      // total*s2 into acc
      C_MULA: begin
        acc_nxt  = alu_res;
        mq_nxt   = mq_r << 1;
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          state_nxt = C_DIFF;
        end
      end
      // variance numerator, kept only when strictly positive
      C_DIFF: begin
        var_pos_nxt = alu_ge && (alu_res != '0);
        if (alu_ge && (alu_res != '0)) begin
          x_nxt = alu_res;
        end
        acc_nxt   = '0;
        mq_nxt    = tot_aligned;
        step_nxt  = SW'(hmv_pkg::TOT_W);
        state_nxt = C_MULC;
      end
      // total*total into den2, then seed the mean division
      C_MULC: begin
        acc_nxt  = alu_res;
        mq_nxt   = mq_r << 1;
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          den2_nxt  = alu_res[hmv_pkg::DEN2_W-1:0];
          acc_nxt   = rem_m;
          nq_nxt    = {low_m, {(hmv_pkg::VAR_W - hmv_pkg::MEAN_W){1'b0}}};
          state_nxt = C_MCHK;
        end
      end
      // quotient would not fit: saturate
      C_MCHK: begin
        if (alu_ge) begin
          mean_nxt = '1;
          bad_nxt  = 1'b1;
          go_var   = 1'b1;
        end else begin
          step_nxt  = SW'(hmv_pkg::MEAN_W);
          state_nxt = C_MDIV;
        end
      end
      C_MDIV: begin
        acc_nxt  = div_nxt;
        nq_nxt   = {nq_r[hmv_pkg::VAR_W-2:0], alu_ge};
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          mean_nxt = {nq_r[hmv_pkg::MEAN_W-2:0], alu_ge};
          go_var   = 1'b1;
        end
      end
      C_VCHK: begin
        if (alu_ge) begin
          nq_nxt    = '1;
          bad_nxt   = 1'b1;
          state_nxt = C_DONE;
        end else begin
          step_nxt  = SW'(hmv_pkg::VAR_W);
          state_nxt = C_VDIV;
        end
      end
      C_VDIV: begin
        acc_nxt  = div_nxt;
        nq_nxt   = {nq_r[hmv_pkg::VAR_W-2:0], alu_ge};
        step_nxt = step_r - 1'b1;
        if (last_step) begin
          state_nxt = C_DONE;
        end
      end
      C_DONE: begin
        if (ack_i) begin
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase

    // hand over to the variance division, or finish with zero variance
    if (go_var) begin
      if (var_pos_r) begin
        acc_nxt   = rem_v;
        nq_nxt    = low_v;
        state_nxt = C_VCHK;
      end else begin
        nq_nxt    = '0;
        state_nxt = C_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    mq_r      <= mq_nxt;
    acc_r     <= acc_nxt;
    x_r       <= x_nxt;
    den2_r    <= den2_nxt;
    nq_r      <= nq_nxt;
    mean_r    <= mean_nxt;
    var_pos_r <= var_pos_nxt;
    bad_r     <= bad_nxt;
  end

  assign done_o   = (state_r == C_DONE);
  assign mean_o   = mean_r;
  assign var_o    = nq_r;
  assign status_o = bad_r | acc_i.ovf;

endmodule

FILE: hw/rtl/histogram_mean_variance.sv
// Histogram weighted mean/variance. Each bin is taken in a request step, then accumulated;
// no new bin is accepted until that is done. After the last bin the result is computed by
// the shared shift-add/subtract unit handling one bit per cycle.
// An empty-list request gives its zero result via T_ZERO once the output register is free.
// rst_n (synchronous, active low) clears the accumulators, index and both handshakes.
module histogram_mean_variance #(
  parameter int MAX_BINS      = hmv_pkg::MAX_BINS_DEF,
  parameter int FRACTION_BITS = hmv_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hmv_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] bin_count
  input  logic                              in_tlast,   // last_bin
  input  logic [0:0]                        in_tuser,   // [0] empty_list
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hmv_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [25:0] mean_fixed,
                                                        // [59:26] variance_fixed, [63:60] 0
  output logic [0:0]                        out_tuser   // [0] status
);

  localparam int PAD_W = hmv_pkg::OUT_TDATA_W - hmv_pkg::MEAN_W - hmv_pkg::VAR_W;

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_ADD   = 5'b00010,
    T_START = 5'b00100,
    T_WAIT  = 5'b01000,
    T_ZERO  = 5'b10000
  } top_state_t;

  top_state_t                    state_r, state_nxt;
  logic                          last_r, last_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [hmv_pkg::MEAN_W-1:0]    out_mean_r, out_mean_nxt;
  logic [hmv_pkg::VAR_W-1:0]     out_var_r, out_var_nxt;
  logic                          out_status_r, out_status_nxt;

  logic                          in_req;
  logic                          out_free;
  logic                          calc_start;
  logic                          calc_ack;
  logic                          calc_done;
  logic [hmv_pkg::MEAN_W-1:0]    calc_mean;
  logic [hmv_pkg::VAR_W-1:0]     calc_var;
  logic                          calc_status;
  hmv_pkg::acc_ctl_t             acc_ctl;
  hmv_pkg::acc_t                 acc_state;

  assign in_tready = (state_r == T_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  hmv_accum #(
    .MAX_BINS (MAX_BINS)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (acc_ctl),
    .cnt_i (in_tdata[hmv_pkg::CNT_W-1:0]),
    .acc_o (acc_state)
  );

  hmv_calc #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (calc_start),
    .ack_i    (calc_ack),
    .acc_i    (acc_state),
    .done_o   (calc_done),
    .mean_o   (calc_mean),
    .var_o    (calc_var),
    .status_o (calc_status)
  );

  // Control sequencer and output register load
  always_comb begin
    state_nxt      = state_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_mean_nxt   = out_mean_r;
    out_var_nxt    = out_var_r;
    out_status_nxt = out_status_r;
    calc_start     = 1'b0;
    calc_ack       = 1'b0;
    acc_ctl        = '{take: 1'b0, add: 1'b0, clear: 1'b0, last: last_r};

    unique case (state_r)
      T_IDLE: begin
        if (in_req) begin
          if (in_tuser[0]) begin
            acc_ctl.clear = 1'b1;
            state_nxt     = T_ZERO;
          end else begin
            acc_ctl.take = 1'b1;
            last_nxt     = in_tlast;
            state_nxt    = T_ADD;
          end
        end
      end
      T_ADD: begin
        acc_ctl.add = 1'b1;
        state_nxt   = last_r ? T_START : T_IDLE;
      end
      T_START: begin
        calc_start = 1'b1;
        state_nxt  = T_WAIT;
      end
      T_WAIT: begin
        if (calc_done && out_free) begin
          calc_ack       = 1'b1;
          acc_ctl.clear  = 1'b1;
          out_valid_nxt  = 1'b1;
          out_mean_nxt   = calc_mean;
          out_var_nxt    = calc_var;
          out_status_nxt = calc_status;
          state_nxt      = T_IDLE;
        end
      end
      T_ZERO: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_mean_nxt   = '0;
          out_var_nxt    = '0;
          out_status_nxt = hmv_pkg::ST_OK;
          state_nxt      = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mean_r   <= out_mean_nxt;
    out_var_r    <= out_var_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_var_r, out_mean_r};
  assign out_tuser  = out_status_r;

endmodule

FILE: hw/rtl/hmv_checker.sv
// Port-level checks for histogram_mean_variance, attached with bind.
// Depends on hmv_pkg and the top-level port list.
module hmv_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [hmv_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [0:0]                        out_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Every accepted request makes the block drop in_tready
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("block ready right after a request");

  // A fresh result is only produced out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while block was idle");

  // Padding bits above the two result fields stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      out_tdata[hmv_pkg::OUT_TDATA_W-1:hmv_pkg::MEAN_W+hmv_pkg::VAR_W] == '0)
    else $error("nonzero padding in result");

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind histogram_mean_variance hmv_checker u_hmv_checker (.*);
